FILE: design/rgbbmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbbmp_pkg
// Shared constants, types and helper functions for the RGB565 to BMP
// byte stream core.
// ----------------------------------------------------------------------------
package rgbbmp_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CNT_W     = $clog2(MAX_DIM);
  localparam int CFG_IDX_W = 8;
  localparam int IDX_W     = 6;

  localparam logic [IDX_W-1:0] HDR_LEN  = IDX_W'(54);
  localparam logic [IDX_W-1:0] PIX_LAST = IDX_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Everything the byte sequencer needs to emit the bytes of one pixel.
  typedef struct packed {
    logic             hdr;
    logic             frame_last;
    logic [IDX_W-1:0] last_idx;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    dim_t             width;
    dim_t             height;
    logic [31:0]      fsize;
  } work_t;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [7:0] scale5(input logic [4:0] c);
    logic [13:0] t;
    t = {9'd0, c} * 14'd527 + 14'd23;
    return t[13:6];
  endfunction

  function automatic logic [7:0] scale6(input logic [5:0] c);
    logic [13:0] t;
    t = {8'd0, c} * 14'd259 + 14'd33;
    return t[13:6];
  endfunction

  // Byte idx of the 54-byte BMP file and info header.
  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input dim_t w,
                                          input dim_t h, input logic [31:0] fsize);
    logic [31:0] w32;
    logic [31:0] nh32;
    logic [7:0]  b;
    w32  = {{(32-DIM_W){1'b0}}, w};
    nh32 = 32'd0 - {{(32-DIM_W){1'b0}}, h};
    unique case (idx)
      6'd0:    b = 8'h42;
      6'd1:    b = 8'h4D;
      6'd2:    b = fsize[7:0];
      6'd3:    b = fsize[15:8];
      6'd4:    b = fsize[23:16];
      6'd5:    b = fsize[31:24];
      6'd10:   b = 8'd54;
      6'd14:   b = 8'd40;
      6'd18:   b = w32[7:0];
      6'd19:   b = w32[15:8];
      6'd20:   b = w32[23:16];
      6'd21:   b = w32[31:24];
      6'd22:   b = nh32[7:0];
      6'd23:   b = nh32[15:8];
      6'd24:   b = nh32[23:16];
      6'd25:   b = nh32[31:24];
      6'd26:   b = 8'd1;
      6'd28:   b = 8'd24;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: design/rgb565_to_bmp_byte_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_to_bmp_byte_stream_core
// Turns RGB565 pixels of a frame into the byte stream of a top-down 24-bit
// BMP file: header before the first pixel, BGR bytes, zero row padding.
// ----------------------------------------------------------------------------
// Timing: the first byte of a pixel passes from the pixel transaction into the
//   work register and from there into the output register, which drives out_.
// Output: one byte per cycle while out_tready allows; a pixel gives 3 bytes, plus
//   54 header bytes and 0 to 3 row padding bytes; the byte sequencer sets this.
// Reset: synchronous, active low; counters clear, sizes return to 640x480.
module rgb565_to_bmp_byte_stream_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // Pixel stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel
  // File byte stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // frame_end
  output logic [0:0]  out_tuser   // [0] last_of_item
);

  rgbbmp_pkg::dim_t  width_r, height_r;
  rgbbmp_pkg::cnt_t  col_r, row_r;
  logic              hdr_done_r;

  logic              work_v_r;
  rgbbmp_pkg::work_t work_r, work_nxt;
  logic [rgbbmp_pkg::IDX_W-1:0] idx_r;

  logic              out_v_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r, out_end_r;

  rgbbmp_pkg::dim_t  w_c, h_c;
  logic              col_end, row_end;
  logic [1:0]        pad;
  logic [14:0]       padded_row;
  logic [27:0]       pix_bytes;
  logic              in_acc, advance, at_last;
  logic [rgbbmp_pkg::IDX_W-1:0] pix_idx;
  logic [7:0]        byte_sel;

  assign cfg_ready = 1'b1;

  assign w_c     = rgbbmp_pkg::clamp_dim(width_r);
  assign h_c     = rgbbmp_pkg::clamp_dim(height_r);
  assign col_end = ({1'b0, col_r} + rgbbmp_pkg::DIM_W'(1)) >= w_c;
  assign row_end = ({1'b0, row_r} + rgbbmp_pkg::DIM_W'(1)) >= h_c;
  // Row padding to a multiple of four bytes equals width mod 4 for 3-byte pixels.
  assign pad        = w_c[1:0];
  assign padded_row = {w_c, 1'b0} + {2'b00, w_c} + {13'd0, pad};
  assign pix_bytes  = {13'd0, padded_row} * {15'd0, h_c};

  assign advance   = work_v_r && (!out_v_r || out_tready);
  assign at_last   = idx_r == work_r.last_idx;
  assign in_tready = !work_v_r || (advance && at_last);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    work_nxt            = '0;
    work_nxt.hdr        = !hdr_done_r;
    work_nxt.frame_last = col_end && row_end;
    work_nxt.last_idx   = (hdr_done_r ? '0 : rgbbmp_pkg::HDR_LEN) + rgbbmp_pkg::PIX_LAST
                          + {4'd0, (col_end ? pad : 2'b00)};
    work_nxt.blue       = rgbbmp_pkg::scale5(in_tdata[4:0]);
    work_nxt.green      = rgbbmp_pkg::scale6(in_tdata[10:5]);
    work_nxt.red        = rgbbmp_pkg::scale5(in_tdata[15:11]);
    work_nxt.width      = w_c;
    work_nxt.height     = h_c;
    work_nxt.fsize      = {4'd0, pix_bytes} + 32'd54;
  end

  always_comb begin
    pix_idx = idx_r - (work_r.hdr ? rgbbmp_pkg::HDR_LEN : '0);
    if (work_r.hdr && (idx_r < rgbbmp_pkg::HDR_LEN)) begin
      byte_sel = rgbbmp_pkg::hdr_byte(idx_r, work_r.width, work_r.height, work_r.fsize);
    end else begin
      unique case (pix_idx)
        6'd0:    byte_sel = work_r.blue;
        6'd1:    byte_sel = work_r.green;
        6'd2:    byte_sel = work_r.red;
        default: byte_sel = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= rgbbmp_pkg::WIDTH_RESET;
      height_r   <= rgbbmp_pkg::HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      hdr_done_r <= 1'b0;
      work_v_r   <= 1'b0;
      idx_r      <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rgbbmp_pkg::REG_FRAME_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == rgbbmp_pkg::REG_FRAME_HEIGHT) begin
          height_r <= cfg_data;
        end
      end

      if (in_acc) begin
        hdr_done_r <= !(col_end && row_end);
        if (col_end) begin
          col_r <= '0;
          row_r <= row_end ? '0 : row_r + rgbbmp_pkg::CNT_W'(1);
        end else begin
          col_r <= col_r + rgbbmp_pkg::CNT_W'(1);
        end
      end

      if (in_acc) begin
        work_v_r <= 1'b1;
        idx_r    <= '0;
      end else if (advance) begin
        if (at_last) begin
          work_v_r <= 1'b0;
        end else begin
          idx_r <= idx_r + rgbbmp_pkg::IDX_W'(1);
        end
      end

      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      work_r <= work_nxt;
    end
    if (advance) begin
      out_byte_r <= byte_sel;
      out_last_r <= at_last;
      out_end_r  <= at_last && work_r.frame_last;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_end_r;
  assign out_tuser[0] = out_last_r;

  a_end_is_item_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_end_r |-> out_last_r)
    else $error("frame end flagged on a byte that does not close its pixel");

  a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    work_v_r |-> idx_r <= work_r.last_idx)
    else $error("byte index ran past the last byte of the pixel");

  a_header_magic : assert property (@(posedge clk) disable iff (!rst_n)
    advance && work_r.hdr && idx_r == '0 |=> out_tdata == 8'h42)
    else $error("header does not open with the BM signature");

  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_byte_r) && $stable(out_last_r)
      && $stable(out_end_r))
    else $error("output transaction changed while it waited");

endmodule
